// File: hdl/fp32_fp16_converter_pkg.sv
// Package: payload types and constants for the binary32/binary16 converter
package fpcvt_pkg;

  localparam int unsigned NumStages = 3;

  localparam logic [15:0] HalfQnan    = 16'h7E00;
  localparam logic [15:0] HalfSnan    = 16'h7D00;
  localparam logic [14:0] HalfInf     = 15'h7C00;
  localparam logic [14:0] HalfMax     = 15'h7BFF;
  localparam logic [30:0] SglOfHalfMax = 31'h477FE000;
  localparam logic [30:0] SglOfSubMin  = 31'h33800000;
  localparam logic [30:0] SglOfNormMin = 31'h38800000;
  localparam logic [7:0]  BiasDiff     = 8'd112;

  typedef enum logic {
    CmdS2H = 1'b0,
    CmdH2S = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        command;
    logic [31:0] operand_bits;
  } in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        clamped;
    logic        flushed;
  } out_t;

  // Classification of an operand, worked out in the first stage
  typedef struct packed {
    logic        cmd;
    logic        sign;
    logic        special;  // NaN or infinity in the source format
    logic        big;      // single above half maximum
    logic        tiny;     // single below half subnormal minimum
    logic        sub;      // subnormal result (s2h) or subnormal operand (h2s)
    logic        zero;     // zero operand
    logic [7:0]  ex;
    logic [22:0] man;
  } cls_t;

  // Intermediate after shift amount / leading one detect
  typedef struct packed {
    cls_t        c;
    logic [4:0]  sh;       // s2h right shift or h2s leading one position
  } mid_t;

endpackage

// File: hdl/fpcvt_classify.sv
// Stage 1 logic: field split and operand classification
module fpcvt_classify (
  input  fpcvt_pkg::in_t  in_i,
  output fpcvt_pkg::cls_t cls_o
);
  logic [30:0] mag;
  logic [15:0] h;

  always_comb begin
    mag = in_i.operand_bits[30:0];
    h   = in_i.operand_bits[15:0];
    cls_o = '0;
    cls_o.cmd = in_i.command;
    if (in_i.command == fpcvt_pkg::CmdS2H) begin
      cls_o.sign    = in_i.operand_bits[31];
      cls_o.ex      = mag[30:23];
      cls_o.man     = mag[22:0];
      cls_o.special = (mag[30:23] == 8'hFF);
      cls_o.big     = (mag > fpcvt_pkg::SglOfHalfMax);
      cls_o.tiny    = (mag < fpcvt_pkg::SglOfSubMin);
      cls_o.sub     = (mag < fpcvt_pkg::SglOfNormMin);
      cls_o.zero    = (mag == '0);
    end else begin
      cls_o.sign    = h[15];
      cls_o.ex      = {3'b000, h[14:10]};
      cls_o.man     = {h[9:0], 13'd0};
      cls_o.special = (h[14:10] == 5'h1F);
      cls_o.sub     = (h[14:10] == 5'h00);
      cls_o.zero    = (h[14:0] == '0);
    end
  end
endmodule

// File: hdl/fpcvt_shift_calc.sv
// Stage 2 logic: subnormal shift amount and leading one search
module fpcvt_shift_calc (
  input  fpcvt_pkg::cls_t cls_i,
  output fpcvt_pkg::mid_t mid_o
);
  logic [7:0] d;
  logic [3:0] p;

  always_comb begin
    d = 8'd126 - cls_i.ex;
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (cls_i.man[13 + i]) p = i[3:0];
    end
    mid_o.c = cls_i;
    if (cls_i.cmd == fpcvt_pkg::CmdS2H) mid_o.sh = d[4:0];
    else mid_o.sh = {1'b0, p};
  end
endmodule

// File: hdl/fpcvt_assemble.sv
// Stage 3 logic: result assembly
module fpcvt_assemble (
  input  fpcvt_pkg::mid_t mid_i,
  output fpcvt_pkg::out_t out_o
);
  fpcvt_pkg::cls_t c;
  logic [23:0] sig;
  logic [23:0] sh_sig;
  logic [9:0]  hman;
  logic [22:0] nman;
  logic [7:0]  nex;

  always_comb begin
    c      = mid_i.c;
    sig    = {1'b1, c.man};
    sh_sig = sig >> mid_i.sh;
    hman   = c.man[22:13];
    // leading one moves just past bit 22 and drops out
    nman   = {hman, 13'd0} << (5'd10 - mid_i.sh);
    nex    = 8'd103 + {3'b000, mid_i.sh};
    out_o  = '0;
    if (c.cmd == fpcvt_pkg::CmdS2H) begin
      if (c.special) begin
        if (c.man == '0) out_o.result_bits[15:0] = {c.sign, fpcvt_pkg::HalfInf};
        else if (c.man[22]) out_o.result_bits[15:0] = fpcvt_pkg::HalfQnan;
        else out_o.result_bits[15:0] = fpcvt_pkg::HalfSnan;
      end else if (c.big) begin
        out_o.result_bits[15:0] = {c.sign, fpcvt_pkg::HalfMax};
        out_o.clamped = 1'b1;
      end else if (c.tiny) begin
        out_o.flushed = !c.zero;
      end else if (c.sub) begin
        out_o.result_bits[15:0] = {c.sign, 5'd0, sh_sig[9:0]};
      end else begin
        out_o.result_bits[15:0] = {c.sign, 5'(c.ex - fpcvt_pkg::BiasDiff), c.man[22:13]};
      end
    end else begin
      if (c.special) begin
        out_o.result_bits = {c.sign, 8'hFF, c.man};
      end else if (c.zero) begin
        out_o.result_bits = {c.sign, 31'd0};
      end else if (c.sub) begin
        out_o.result_bits = {c.sign, nex, nman};
      end else begin
        out_o.result_bits = {c.sign, c.ex + fpcvt_pkg::BiasDiff, c.man};
      end
    end
  end
endmodule

// File: hdl/fp32_fp16_converter.sv
// Top level: three-stage binary32/binary16 converter
// The done strobe follows the start transfer through the stage valid registers v1_q, v2_q and v3_q.
// Throughput: one item per cycle; busy is held low, the pipe is never stalled.
// Reset: rst_ni asynchronous active low clears the stage valid bits.
module fp32_fp16_converter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  fpcvt_pkg::in_t   in_i,
  output logic             done_o,
  output fpcvt_pkg::out_t  out_o
);
  fpcvt_pkg::cls_t cls_d, cls_q;
  fpcvt_pkg::mid_t mid_d, mid_q;
  fpcvt_pkg::out_t res_d, res_q;
  logic v1_q, v2_q, v3_q;

  assign busy = 1'b0;

  fpcvt_classify   u_cls (.in_i(in_i), .cls_o(cls_d));
  fpcvt_shift_calc u_sh  (.cls_i(cls_q), .mid_o(mid_d));
  fpcvt_assemble   u_asm (.mid_i(mid_q), .out_o(res_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    mid_q <= mid_d;
    res_q <= res_d;
  end

  assign done_o = v3_q;
  assign out_o  = res_q;
endmodule

// File: hdl/fpcvt_checker.sv
// Port checker for the converter, bound to the top level
module fpcvt_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done,
  input fpcvt_pkg::out_t out_o
);
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##3 done) else $error("missing done");
  a_nospur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(start, 3)) else $error("spurious done");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !(out_o.clamped && out_o.flushed)) else $error("both flags");
  a_flagres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && (out_o.clamped || out_o.flushed) |-> out_o.result_bits[31:16] == '0)
    else $error("flag on wide result");
endmodule

bind fp32_fp16_converter fpcvt_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done(done_o), .out_o(out_o)
);

// File: sim/tb_top.sv
// Testbench for the binary32/binary16 converter: random and directed conversions
`timescale 1ns / 100ps

class cvt_scoreboard;
  fpcvt_pkg::out_t expected_q[$];
  int unsigned     fail_count;
  int unsigned     checked_count;

  function new();
    fail_count    = 0;
    checked_count = 0;
  endfunction

  static function fpcvt_pkg::out_t convert(fpcvt_pkg::in_t item);
    fpcvt_pkg::out_t r;
    logic        sgn;
    logic [30:0] mag;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] sig;
    logic [15:0] h;
    logic [4:0]  hex;
    logic [9:0]  hman;
    int          p;
    r = '0;
    if (item.command == fpcvt_pkg::CmdS2H) begin
      sgn = item.operand_bits[31];
      mag = item.operand_bits[30:0];
      ex  = mag[30:23];
      man = mag[22:0];
      if (ex == 8'hFF) begin
        if (man == 0) r.result_bits[15:0] = {sgn, 15'h7C00};
        else if (man[22]) r.result_bits[15:0] = 16'h7E00;
        else r.result_bits[15:0] = 16'h7D00;
      end else if (mag > 31'h477FE000) begin
        r.result_bits[15:0] = {sgn, 15'h7BFF};
        r.clamped = 1'b1;
      end else if (mag < 31'h33800000) begin
        r.flushed = (mag != 0);
      end else if (mag < 31'h38800000) begin
        sig = {1'b1, man};
        r.result_bits[15:0] = {sgn, 5'd0, 10'(sig >> (8'd126 - ex))};
      end else begin
        r.result_bits[15:0] = {sgn, 5'(ex - 8'd112), man[22:13]};
      end
    end else begin
      h    = item.operand_bits[15:0];
      sgn  = h[15];
      hex  = h[14:10];
      hman = h[9:0];
      if (hex == 5'h1F) begin
        r.result_bits = {sgn, 8'hFF, hman, 13'd0};
      end else if (hex == 0) begin
        if (hman == 0) begin
          r.result_bits = {sgn, 31'd0};
        end else begin
          p = 9;
          while (!hman[p]) p--;
          r.result_bits = {sgn, 8'(p + 103), 23'((23'(hman) << (23 - p)))};
        end
      end else begin
        r.result_bits = {sgn, 8'(hex + 8'd112), hman, 13'd0};
      end
    end
    return r;
  endfunction

  function void note_transfer(fpcvt_pkg::in_t item);
    expected_q.push_back(convert(item));
  endfunction

  function void check_result(fpcvt_pkg::out_t got);
    fpcvt_pkg::out_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected result %h", got);
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    checked_count++;
    if (got.result_bits !== want.result_bits) begin
      $error("result_bits: expected %h actual %h", want.result_bits, got.result_bits);
      fail_count++;
    end
    if (got.clamped !== want.clamped) begin
      $error("clamped: expected %b actual %b", want.clamped, got.clamped);
      fail_count++;
    end
    if (got.flushed !== want.flushed) begin
      $error("flushed: expected %b actual %b", want.flushed, got.flushed);
      fail_count++;
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned CycleLimit = 200000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  fpcvt_pkg::in_t  in_d = '0;
  logic            done;
  fpcvt_pkg::out_t out_d;
  int unsigned     idle_pct = 0;
  int unsigned     cycle_count = 0;
  int unsigned     s2h_count = 0;
  int unsigned     h2s_count = 0;
  cvt_scoreboard   sb = new();

  always #5 clk_i = ~clk_i;

  fp32_fp16_converter u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_d),
    .done_o(done),
    .out_o (out_d)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && start && !busy) sb.note_transfer(in_d);
    if (rst_ni && done) sb.check_result(out_d);
    if (cycle_count > CycleLimit) begin
      $display("fp32_fp16_converter verification failed");
      $finish;
    end
  end

  // Present one item and hold it until the transfer edge.
  task automatic send_item(fpcvt_pkg::cmd_e cmd, logic [31:0] bits);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    in_d  <= '{command: cmd, operand_bits: bits};
    if (cmd == fpcvt_pkg::CmdS2H) s2h_count++;
    else h2s_count++;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Well-spread random single: mostly near the half range, some anywhere.
  function automatic logic [31:0] rand_single();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(5))
      0, 1: v[30:23] = 8'($urandom_range(142, 113));
      2:    v[30:23] = 8'($urandom_range(112, 101));
      3:    v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      4:    v[30:23] = 8'($urandom_range(143, 141));
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] directed_s[$];
    logic [15:0] directed_h[$];
    directed_s = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0001, 32'hFFC0_0000, 32'h7F80_0001, 32'hFFBF_FFFF,
                   32'h477F_E000, 32'h477F_E001, 32'hC77F_FFFF, 32'h7F7F_FFFF,
                   32'h3380_0000, 32'h337F_FFFF, 32'h0000_0001, 32'hB87F_FFFF,
                   32'h3880_0000};
    directed_h = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h7C00, 16'hFC00,
                   16'h7E01, 16'hFD55};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed_s[i]) send_item(fpcvt_pkg::CmdS2H, directed_s[i]);
    foreach (directed_h[i]) begin
      send_item(fpcvt_pkg::CmdH2S, {16'hA5A5 ^ 16'(i * 16'h1111), directed_h[i]});
    end
    // sender waits for every outstanding result before the random phases
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 70 : ((ph == 3) ? 19 : 0);
      for (int n = 0; n < 400; n++) begin
        if ($urandom_range(1)) send_item(fpcvt_pkg::CmdS2H, rand_single());
        else send_item(fpcvt_pkg::CmdH2S, $urandom());
      end
    end
    drain();
    repeat (3 * fpcvt_pkg::NumStages + 4) @(negedge clk_i);
    $display("Covered %0d single-to-half and %0d half-to-single conversions, %0d checked.",
             s2h_count, h2s_count, sb.checked_count);
    if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("fp32_fp16_converter verification clean");
    end else begin
      $display("fp32_fp16_converter verification failed");
    end
    $finish;
  end
endmodule
